>>> design/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

    // converter width default
    localparam int ADC_BITS_DEF = 10;

    // sample acceptance window, open on both ends
    localparam int WINDOW_LOW  = 50;
    localparam int WINDOW_HIGH = 1000;

    // average weights: new = (4*avg + sample) / 5
    localparam int KEEP_SHIFT   = 2;
    localparam int TOTAL_WEIGHT = 5;

    // fixed-point hundredths and output limits
    localparam int SCALE          = 100;
    localparam int SPLIT_DIVISOR  = 100;
    localparam int MAG_LIMIT      = 99999;
    localparam int MAG_BITS       = 17;
    localparam int TEMP_WHOLE_W   = 10;
    localparam int TEMP_HUND_W    = 7;

    // calibration degrees width and serial multiplier operand width
    localparam int DEG_W    = 8;
    localparam int MPLIER_W = 9;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOW_READING  = 2'd0,
        CFG_LOW_DEGREES  = 2'd1,
        CFG_HIGH_READING = 2'd2,
        CFG_HIGH_DEGREES = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_DIV,
        ST_CALIB,
        ST_MUL_SPAN,
        ST_MUL_BASE,
        ST_MUL_SCALE,
        ST_TEMP_DIV,
        ST_SPLIT_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic accumulate;
    } mul_ctl_t;

endpackage

`default_nettype wire

>>> design/rsc_sample_if.sv
`default_nettype none

interface rsc_sample_if
    import rsc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

>>> design/rsc_result_if.sv
`default_nettype none

interface rsc_result_if
    import rsc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [ADC_BITS-1:0]     filtered_reading;
    logic                    sample_rejected;
    logic                    calibration_error;
    logic                    temp_negative;
    logic [TEMP_WHOLE_W-1:0] temp_whole;
    logic [TEMP_HUND_W-1:0]  temp_hundredths;
    logic                    temp_saturated;

    modport source (
        output valid, output filtered_reading, output sample_rejected,
        output calibration_error, output temp_negative, output temp_whole,
        output temp_hundredths, output temp_saturated, input ready
    );
    modport sink (
        input valid, input filtered_reading, input sample_rejected,
        input calibration_error, input temp_negative, input temp_whole,
        input temp_hundredths, input temp_saturated, output ready
    );
endinterface

`default_nettype wire

>>> design/rsc_mul.sv
`default_nettype none

// radix-2 shift-add multiplier, one multiplier bit per cycle
module rsc_mul
    import rsc_pkg::*;
#(
    parameter int AW = ADC_BITS_DEF + 17
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mul_ctl_t             ctl,
    input  wire logic signed [AW-1:0] mcand,
    input  wire logic signed [MPLIER_W-1:0] mplier,
    output      logic                 done,
    output      logic signed [AW-1:0] acc
);
    localparam int CNT_W = $clog2(MPLIER_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [AW-1:0]      mcand_reg, mcand_next;
    logic [MPLIER_W-1:0]       mplier_reg, mplier_next;
    logic signed [AW-1:0]      acc_reg, acc_next;
    logic                      last_step;

    // top bit of the multiplier carries negative weight
    assign last_step = (cnt_reg == CNT_W'(MPLIER_W - 1));

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (ctl.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
            if (!ctl.accumulate)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = last_step ? (acc_reg - mcand_reg) : (acc_reg + mcand_reg);
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

>>> design/rsc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle, dividend given msb-aligned
module rsc_div
    import rsc_pkg::*;
#(
    parameter int DW = ADC_BITS_DEF + 17,
    parameter int VW = ADC_BITS_DEF,
    parameter int CW = $clog2(DW + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    input  wire logic [CW-1:0] len,
    output      logic          done,
    output      logic [DW-1:0] quotient,
    output      logic [VW-1:0] remainder
);
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = len;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> design/rtd_sample_filter_and_calibrate.sv
// per sample: average divide, skipped when the sample is rejected or primes the average;
//   on a calibration error straight to emit, else three multiplier runs of 9 steps (span,
//   base, scale), then the temperature and split divides; emit waits for a free output register
// one sample in flight: the next sample is taken back in idle after the result register
//   loads, so the serial divider and multiplier runs set the pace
// reset: async active low; clears average, primed flag, calibration and control state
`default_nettype none

module rtd_sample_filter_and_calibrate
    import rsc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rsc_sample_if.sink                  sample_ch,
    rsc_result_if.source                result_ch,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ADC_BITS-1:0]    cfg_data
);
    // numerator width: 100 * (ld*den + (avg-lr)*(hd-ld)) stays below 2^(ADC_BITS+16)
    localparam int NW     = ADC_BITS + 17;
    localparam int CW     = $clog2(NW + 1);
    localparam int AVG_DW = ADC_BITS + KEEP_SHIFT + 1;

    // control state
    state_t state_reg, state_next;
    logic   primed_reg, primed_next;
    logic   out_valid_reg, out_valid_next;

    // running average and calibration points
    logic [ADC_BITS-1:0]     avg_reg, avg_next;
    logic [ADC_BITS-1:0]     lr_reg;
    logic [ADC_BITS-1:0]     hr_reg;
    logic signed [DEG_W-1:0] ld_reg;
    logic signed [DEG_W-1:0] hd_reg;

    // per-sample working flags and fields
    logic                    rej_reg, rej_next;
    logic                    cal_err_reg, cal_err_next;
    logic                    neg_reg, neg_next;
    logic                    sat_reg, sat_next;
    logic [TEMP_WHOLE_W-1:0] whole_reg, whole_next;
    logic [TEMP_HUND_W-1:0]  hund_reg, hund_next;

    // output register
    logic [ADC_BITS-1:0]     o_filt_reg, o_filt_next;
    logic                    o_rej_reg, o_rej_next;
    logic                    o_cal_err_reg, o_cal_err_next;
    logic                    o_neg_reg, o_neg_next;
    logic [TEMP_WHOLE_W-1:0] o_whole_reg, o_whole_next;
    logic [TEMP_HUND_W-1:0]  o_hund_reg, o_hund_next;
    logic                    o_sat_reg, o_sat_next;

    // multiplier hookup
    mul_ctl_t                   mul_ctl;
    logic signed [NW-1:0]       mul_a;
    logic signed [MPLIER_W-1:0] mul_b;
    logic                       mul_done;
    logic signed [NW-1:0]       mul_acc;

    // divider hookup
    logic                div_start;
    logic [NW-1:0]       div_dividend;
    logic [ADC_BITS-1:0] div_divisor;
    logic [CW-1:0]       div_len;
    logic                div_done;
    logic [NW-1:0]       quo;
    logic [ADC_BITS-1:0] rem;

    // datapath terms
    logic [AVG_DW-1:0]          avg_sum;
    logic                       in_window;
    logic signed [ADC_BITS:0]   den_s;
    logic [ADC_BITS-1:0]        den_mag;
    logic signed [ADC_BITS:0]   offs_s;
    logic signed [MPLIER_W-1:0] span_s;
    logic signed [MPLIER_W-1:0] base_s;
    logic [NW-1:0]              num_mag;
    logic                       over_limit;
    logic [MAG_BITS-1:0]        mag_clamp;

    rsc_mul #(
        .AW (NW)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .acc    (mul_acc)
    );

    rsc_div #(
        .DW (NW),
        .VW (ADC_BITS),
        .CW (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .len       (div_len),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // 4*avg + sample, divided by 5 in the serial divider
    assign avg_sum   = (AVG_DW'(avg_reg) << KEEP_SHIFT) + AVG_DW'(sample_ch.adc_sample);
    assign in_window = (int'(sample_ch.adc_sample) > WINDOW_LOW)
                    && (int'(sample_ch.adc_sample) < WINDOW_HIGH);

    // line through the two calibration points
    assign den_s   = $signed({1'b0, hr_reg}) - $signed({1'b0, lr_reg});
    assign den_mag = den_s[ADC_BITS] ? ADC_BITS'(-den_s) : den_s[ADC_BITS-1:0];
    assign offs_s  = $signed({1'b0, avg_reg}) - $signed({1'b0, lr_reg});
    assign span_s  = MPLIER_W'(hd_reg) - MPLIER_W'(ld_reg);
    assign base_s  = MPLIER_W'(ld_reg);

    // magnitude of the scaled numerator, sign handled apart
    assign num_mag = mul_acc[NW-1] ? $unsigned(-mul_acc) : $unsigned(mul_acc);

    // clamp at 999.99 before splitting into whole and hundredths
    assign over_limit = (quo > NW'(MAG_LIMIT));
    assign mag_clamp  = over_limit ? MAG_BITS'(MAG_LIMIT) : quo[MAG_BITS-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        primed_next    = primed_reg;
        avg_next       = avg_reg;
        rej_next       = rej_reg;
        cal_err_next   = cal_err_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        whole_next     = whole_reg;
        hund_next      = hund_reg;
        mul_ctl        = '0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        div_len        = '0;
        // result register drains on its own beat
        out_valid_next = out_valid_reg && !result_ch.ready;
        o_filt_next    = o_filt_reg;
        o_rej_next     = o_rej_reg;
        o_cal_err_next = o_cal_err_reg;
        o_neg_next     = o_neg_reg;
        o_whole_next   = o_whole_reg;
        o_hund_next    = o_hund_reg;
        o_sat_next     = o_sat_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    if (!primed_reg)
                    begin
                        // first sample after reset loads the average, no window test
                        avg_next    = sample_ch.adc_sample;
                        primed_next = 1'b1;
                        rej_next    = 1'b0;
                        state_next  = ST_CALIB;
                    end
                    else if (in_window)
                    begin
                        rej_next     = 1'b0;
                        div_start    = 1'b1;
                        div_dividend = NW'(avg_sum) << (NW - AVG_DW);
                        div_divisor  = ADC_BITS'(TOTAL_WEIGHT);
                        div_len      = CW'(AVG_DW);
                        state_next   = ST_AVG_DIV;
                    end
                    else
                    begin
                        // out-of-window sample keeps the average
                        rej_next   = 1'b1;
                        state_next = ST_CALIB;
                    end
                end
            end

            ST_AVG_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = quo[ADC_BITS-1:0];
                    state_next = ST_CALIB;
                end
            end

            ST_CALIB:
            begin
                if (hr_reg == lr_reg)
                begin
                    // degenerate calibration: no temperature
                    cal_err_next = 1'b1;
                    neg_next     = 1'b0;
                    sat_next     = 1'b0;
                    whole_next   = '0;
                    hund_next    = '0;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cal_err_next = 1'b0;
                    mul_ctl      = '{start: 1'b1, accumulate: 1'b0};
                    mul_a        = NW'(offs_s);
                    mul_b        = span_s;
                    state_next   = ST_MUL_SPAN;
                end
            end

            ST_MUL_SPAN:
            begin
                // add low degrees times reading span
                if (mul_done)
                begin
                    mul_ctl    = '{start: 1'b1, accumulate: 1'b1};
                    mul_a      = NW'(den_s);
                    mul_b      = base_s;
                    state_next = ST_MUL_BASE;
                end
            end

            ST_MUL_BASE:
            begin
                // scale to hundredths
                if (mul_done)
                begin
                    mul_ctl    = '{start: 1'b1, accumulate: 1'b0};
                    mul_a      = mul_acc;
                    mul_b      = MPLIER_W'(SCALE);
                    state_next = ST_MUL_SCALE;
                end
            end

            ST_MUL_SCALE:
            begin
                if (mul_done)
                begin
                    // sign of the exact quotient, even when it truncates to zero
                    neg_next     = (mul_acc != '0) && (mul_acc[NW-1] != den_s[ADC_BITS]);
                    div_start    = 1'b1;
                    div_dividend = num_mag;
                    div_divisor  = den_mag;
                    div_len      = CW'(NW);
                    state_next   = ST_TEMP_DIV;
                end
            end

            ST_TEMP_DIV:
            begin
                if (div_done)
                begin
                    sat_next     = over_limit;
                    div_start    = 1'b1;
                    div_dividend = NW'(mag_clamp) << (NW - MAG_BITS);
                    div_divisor  = ADC_BITS'(SPLIT_DIVISOR);
                    div_len      = CW'(MAG_BITS);
                    state_next   = ST_SPLIT_DIV;
                end
            end

            ST_SPLIT_DIV:
            begin
                if (div_done)
                begin
                    whole_next = quo[TEMP_WHOLE_W-1:0];
                    hund_next  = rem[TEMP_HUND_W-1:0];
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    o_filt_next    = avg_reg;
                    o_rej_next     = rej_reg;
                    o_cal_err_next = cal_err_reg;
                    o_neg_next     = neg_reg;
                    o_whole_next   = whole_reg;
                    o_hund_next    = hund_reg;
                    o_sat_next     = sat_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            avg_reg       <= avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // calibration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= '0;
            ld_reg <= '0;
            hr_reg <= '0;
            hd_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LOW_READING:  lr_reg <= cfg_data;
                CFG_LOW_DEGREES:  ld_reg <= cfg_data[DEG_W-1:0];
                CFG_HIGH_READING: hr_reg <= cfg_data;
                CFG_HIGH_DEGREES: hd_reg <= cfg_data[DEG_W-1:0];
                default:          ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rej_reg       <= rej_next;
        cal_err_reg   <= cal_err_next;
        neg_reg       <= neg_next;
        sat_reg       <= sat_next;
        whole_reg     <= whole_next;
        hund_reg      <= hund_next;
        o_filt_reg    <= o_filt_next;
        o_rej_reg     <= o_rej_next;
        o_cal_err_reg <= o_cal_err_next;
        o_neg_reg     <= o_neg_next;
        o_whole_reg   <= o_whole_next;
        o_hund_reg    <= o_hund_next;
        o_sat_reg     <= o_sat_next;
    end

    // one sample in flight; taken only in idle
    assign sample_ch.ready = (state_reg == ST_IDLE);

    assign result_ch.valid             = out_valid_reg;
    assign result_ch.filtered_reading  = o_filt_reg;
    assign result_ch.sample_rejected   = o_rej_reg;
    assign result_ch.calibration_error = o_cal_err_reg;
    assign result_ch.temp_negative     = o_neg_reg;
    assign result_ch.temp_whole        = o_whole_reg;
    assign result_ch.temp_hundredths   = o_hund_reg;
    assign result_ch.temp_saturated    = o_sat_reg;

endmodule

`default_nettype wire

>>> design/rsc_checker.sv
`default_nettype none

module rsc_checker
    import rsc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    rsc_sample_if.sink   sample_ch,
    rsc_result_if.source result_ch
);
    // no temperature fields on a calibration error
    a_cal_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.calibration_error |->
            !result_ch.temp_negative && !result_ch.temp_saturated
            && result_ch.temp_whole == '0 && result_ch.temp_hundredths == '0)
        else $error("calibration error beat carries temperature");

    // clamp gives exactly 999.99
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.temp_saturated |->
            result_ch.temp_whole == TEMP_WHOLE_W'(999)
            && result_ch.temp_hundredths == TEMP_HUND_W'(99))
        else $error("saturated beat not clamped to 999.99");

    // split into whole and hundredths stays in range
    a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |->
            result_ch.temp_hundredths <= TEMP_HUND_W'(99)
            && result_ch.temp_whole <= TEMP_WHOLE_W'(999))
        else $error("temperature fields out of range");

    // only one sample in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.valid && sample_ch.ready |=> !sample_ch.ready)
        else $error("sample taken while another is in flight");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && !result_ch.ready |=>
            result_ch.valid && $stable(result_ch.filtered_reading))
        else $error("stalled result beat changed");

endmodule

bind rtd_sample_filter_and_calibrate rsc_checker u_rsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
);

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsc_pkg::*;

    localparam int ABITS        = ADC_BITS_DEF;
    localparam int LATENCY      = 2 * ABITS + 73;   // sample beat to result beat
    localparam int RANDOM_ITEMS = 700;
    localparam int ROUND_ITEMS  = 50;               // samples per random calibration

    // one result beat, field for field
    typedef struct packed {
        logic [ABITS-1:0]        filtered_reading;
        logic                    sample_rejected;
        logic                    calibration_error;
        logic                    temp_negative;
        logic [TEMP_WHOLE_W-1:0] temp_whole;
        logic [TEMP_HUND_W-1:0]  temp_hundredths;
        logic                    temp_saturated;
    } temp_reading_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [ABITS-1:0] cfg_data;

    rsc_sample_if #(.ADC_BITS(ABITS)) sample_ch ();
    rsc_result_if #(.ADC_BITS(ABITS)) result_ch ();

    rtd_sample_filter_and_calibrate #(.ADC_BITS(ABITS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of the filter state and calibration points
    logic [ABITS-1:0] avg_model;
    logic             avg_primed;
    logic [ABITS-1:0] cal_low_reading;
    logic [ABITS-1:0] cal_high_reading;
    logic signed [7:0] cal_low_deg;
    logic signed [7:0] cal_high_deg;

    // expected results, oldest first
    temp_reading_t pending_readings[$];

    // idling knobs, in percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;          // cycles of forced receiver hold-off still to go

    int error_count;
    int items_sent;
    int settings_loaded;
    int beats_checked;
    int rejected_seen;
    int cal_err_seen;
    int negative_seen;
    int saturated_seen;

    // ------------------------------------------------------------------
    // predictor: advance the running average with one sample, then map it
    // through the line between the two calibration points in hundredths
    // ------------------------------------------------------------------
    function automatic temp_reading_t filter_and_calibrate(input logic [ABITS-1:0] sample);
        temp_reading_t r;
        longint        span;
        longint        num;
        longint        mag;
        r = '0;

        // first beat after reset loads the average with no window test
        if (!avg_primed)
        begin
            avg_model  = sample;
            avg_primed = 1'b1;
        end
        else if (int'(sample) > WINDOW_LOW && int'(sample) < WINDOW_HIGH)
        begin
            avg_model = ABITS'((longint'(avg_model) * 4 + longint'(sample)) / TOTAL_WEIGHT);
        end
        else
        begin
            r.sample_rejected = 1'b1;
        end
        r.filtered_reading = avg_model;

        if (cal_high_reading == cal_low_reading)
        begin
            // degenerate line: flag only, temperature fields stay zero
            r.calibration_error = 1'b1;
        end
        else
        begin
            span = longint'(cal_high_reading) - longint'(cal_low_reading);
            num  = longint'(cal_low_deg) * SCALE * span
                 + (longint'(avg_model) - longint'(cal_low_reading))
                   * (longint'(cal_high_deg) - longint'(cal_low_deg)) * SCALE;
            mag  = (num < 0 ? -num : num) / (span < 0 ? -span : span);
            // sign comes from the exact quotient, so -0.00 is still negative
            r.temp_negative = (num != 0) && ((num < 0) != (span < 0));
            if (mag > MAG_LIMIT)
            begin
                mag              = MAG_LIMIT;
                r.temp_saturated = 1'b1;
            end
            r.temp_whole      = TEMP_WHOLE_W'(mag / SPLIT_DIVISOR);
            r.temp_hundredths = TEMP_HUND_W'(mag % SPLIT_DIVISOR);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, plus a counted hold-off for pressure
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // every accepted result beat is held against the oldest expectation
    always @(posedge clk)
    begin
        temp_reading_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, filtered %0d",
                         $time, result_ch.filtered_reading);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                beats_checked++;
                rejected_seen  += want.sample_rejected;
                cal_err_seen   += want.calibration_error;
                negative_seen  += want.temp_negative;
                saturated_seen += want.temp_saturated;
                check_field("filtered_reading", want.filtered_reading,
                            result_ch.filtered_reading);
                check_field("sample_rejected", want.sample_rejected,
                            result_ch.sample_rejected);
                check_field("calibration_error", want.calibration_error,
                            result_ch.calibration_error);
                check_field("temp_negative", want.temp_negative, result_ch.temp_negative);
                check_field("temp_whole", want.temp_whole, result_ch.temp_whole);
                check_field("temp_hundredths", want.temp_hundredths,
                            result_ch.temp_hundredths);
                check_field("temp_saturated", want.temp_saturated, result_ch.temp_saturated);
            end
        end
    end

    // ------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------

    // offer one sample beat after a random gap; predict once it is taken.
    // valid stays high afterwards so back-to-back beats need no toggle
    task automatic send_sample(input logic [ABITS-1:0] value);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_readings.push_back(filter_and_calibrate(value));
        items_sent++;
    endtask

    // drop valid and wait until every result beat is back
    task automatic wait_idle();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [ABITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_LOW_READING:  cal_low_reading  = value;
            CFG_LOW_DEGREES:  cal_low_deg      = value[7:0];
            CFG_HIGH_READING: cal_high_reading = value;
            CFG_HIGH_DEGREES: cal_high_deg     = value[7:0];
            default: ;
        endcase
    endtask

    // degrees go out with random upper bits, only the low byte counts
    task automatic load_calibration(input logic [ABITS-1:0] lo_rd, input int lo_deg,
                                    input logic [ABITS-1:0] hi_rd, input int hi_deg);
        wait_idle();
        write_reg(CFG_LOW_READING, lo_rd);
        write_reg(CFG_LOW_DEGREES, ABITS'({$urandom(), 8'(lo_deg)}));
        write_reg(CFG_HIGH_READING, hi_rd);
        write_reg(CFG_HIGH_DEGREES, ABITS'({$urandom(), 8'(hi_deg)}));
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // walk the average to an exact value with in-window samples
    task automatic steer_average(input int target);
        int guess;
        while (int'(avg_model) != target)
        begin
            guess = TOTAL_WEIGHT * target - 4 * int'(avg_model);
            if (guess < WINDOW_LOW + 1)
                guess = WINDOW_LOW + 1;
            if (guess > WINDOW_HIGH - 1)
                guess = WINDOW_HIGH - 1;
            send_sample(ABITS'(guess));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // calibration still at reset, so both readings are equal: error flag.
    // the first beat loads the average even though it is out of window
    task automatic test_first_sample();
        set_idling(0, 0);
        send_sample('1);
        send_sample('1);
        send_sample('0);
        send_sample(ABITS'(WINDOW_LOW + 1));
    endtask

    // window is open on both ends
    task automatic test_window_edges();
        load_calibration('0, 0, ABITS'(1000), 100);
        send_sample(ABITS'(WINDOW_LOW));
        send_sample(ABITS'(WINDOW_LOW + 1));
        send_sample(ABITS'(WINDOW_HIGH - 1));
        send_sample(ABITS'(WINDOW_HIGH));
        send_sample(ABITS'(WINDOW_LOW - 1));
        send_sample(ABITS'(WINDOW_HIGH + 1));
    endtask

    // -0.002 truncates to 0.00 but keeps its sign; exact zero has none;
    // a falling line (negative span) gives a positive fraction
    task automatic test_sign_and_fraction();
        load_calibration('0, -1, ABITS'(1000), 1);
        steer_average(499);
        steer_average(500);
        load_calibration(ABITS'(1000), 1, '0, -1);
        steer_average(501);
    endtask

    // steep lines clamp at 999.99 either side of zero, then a full-range line with extreme degrees
    task automatic test_saturation();
        load_calibration('0, 0, ABITS'(1), 127);
        send_sample(avg_model);
        load_calibration('0, 0, ABITS'(1), -128);
        send_sample(avg_model);
        load_calibration('1, -128, '0, 127);
        send_sample('1);
    endtask

    // receiver holds off for many latencies while beats keep coming,
    // so the output register fills and the input stalls
    task automatic test_output_backpressure();
        load_calibration(ABITS'(100), -20, ABITS'(900), 110);
        set_idling(0, 0);
        @(posedge clk);
        hold_left = 8 * LATENCY;
        repeat (8)
            send_sample(ABITS'($urandom_range(WINDOW_HIGH - 1, WINDOW_LOW + 1)));
    endtask

    // random calibrations, mostly in-window samples, edges and noise,
    // cycling through the idling phases
    task automatic test_random_mix();
        int               round;
        int               deg_lo;
        int               deg_hi;
        logic [ABITS-1:0] rd_lo;
        logic [ABITS-1:0] rd_hi;
        logic [ABITS-1:0] sample;
        for (round = 0; round < RANDOM_ITEMS / ROUND_ITEMS; round++)
        begin
            case (round % 4)
                0: set_idling(0, 0);
                1: set_idling(81, 0);
                2: set_idling(0, 81);
                default: set_idling(18, 18);
            endcase

            rd_lo = ABITS'($urandom());
            case ($urandom_range(9, 0))
                0: rd_hi = rd_lo;                   // degenerate line
                1: begin rd_lo = '0; rd_hi = '1; end
                2: begin rd_lo = '1; rd_hi = '0; end
                default: rd_hi = ABITS'($urandom());
            endcase
            deg_lo = ($urandom_range(3, 0) == 0) ? int'($urandom_range(255, 0)) - 128
                                                 : int'($urandom_range(130, 0)) - 20;
            deg_hi = ($urandom_range(3, 0) == 0) ? int'($urandom_range(255, 0)) - 128
                                                 : int'($urandom_range(130, 0)) - 20;
            load_calibration(rd_lo, deg_lo, rd_hi, deg_hi);

            repeat (ROUND_ITEMS)
            begin
                case ($urandom_range(9, 0))
                    0: sample = ABITS'($urandom_range(WINDOW_LOW + 2, WINDOW_LOW - 2));
                    1: sample = ABITS'($urandom_range(WINDOW_HIGH + 2, WINDOW_HIGH - 2));
                    2: sample = ABITS'($urandom());
                    default: sample = ABITS'($urandom_range(WINDOW_HIGH - 1, WINDOW_LOW + 1));
                endcase
                send_sample(sample);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------
    initial
    begin
        // every input known from time zero
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        result_ch.ready      = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_LOW_READING;
        cfg_data             = '0;

        avg_model        = '0;
        avg_primed       = 1'b0;
        cal_low_reading  = '0;
        cal_high_reading = '0;
        cal_low_deg      = '0;
        cal_high_deg     = '0;

        hold_left       = 0;
        error_count     = 0;
        items_sent      = 0;
        settings_loaded = 0;
        beats_checked   = 0;
        rejected_seen   = 0;
        cal_err_seen    = 0;
        negative_seen   = 0;
        saturated_seen  = 0;
        set_idling(0, 0);

        // reset held low from time zero, released on a falling edge
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_first_sample();
        test_window_edges();
        test_sign_and_fraction();
        test_saturation();
        test_output_backpressure();
        test_random_mix();

        // drain, then leave room for any stray beat to show up
        wait_idle();
        repeat (2 * LATENCY)
            @(posedge clk);

        $display("summary: %0d samples, %0d result beats checked, %0d calibration settings",
                 items_sent, beats_checked, settings_loaded);
        $display("summary: %0d rejected, %0d calibration errors, %0d negative, %0d clamped",
                 rejected_seen, cal_err_seen, negative_seen, saturated_seen);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("timeout with %0d result beats still expected", pending_readings.size());
        $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
design/rsc_pkg.sv
design/rsc_sample_if.sv
design/rsc_result_if.sv
design/rsc_mul.sv
design/rsc_div.sv
design/rtd_sample_filter_and_calibrate.sv
design/rsc_checker.sv
verif/tb.sv
